// File: hw/rtl/mvfb_pkg.sv
`default_nettype none

package mvfb_pkg;

    // field and register widths
    localparam int unsigned PIX_W    = 32;
    localparam int unsigned MASK_W   = 8;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned LEVEL_W  = 15;
    localparam int unsigned HEIGHT_W = 13;
    localparam int unsigned S_DATA_W = 88;

    // |bottom - top| fits 15 bits, times a 12-bit row
    localparam int unsigned DMAG_W = 15;
    localparam int unsigned NUM_W  = DMAG_W + ROW_W;

    // opacity after clamping, 0..256
    localparam int unsigned TR_W = 9;
    localparam logic [TR_W-1:0] TR_FULL = 9'd256;
    localparam logic [MASK_W-1:0] MASK_FULL = 8'hFF;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_TOP    = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0]  src;
        logic [PIX_W-1:0]  dst;
        logic [MASK_W-1:0] mask;
    } t_side;

endpackage

`default_nettype wire

// File: hw/rtl/masked_vertical_fade_blend.sv
// Input transaction to output valid passes through 33 registers
// (input register, gradient multiply, 27 restoring divider stages, clamp, weight, mix, output).
// Throughput: one pixel per cycle while the skid is empty; the divider is fully pipelined.
// A two-entry output buffer keeps the pipeline moving one extra transaction under backpressure.
// Reset (synchronous, active low) clears all valid bits and loads top = 256, bottom = 256,
// height = 1.
`default_nettype none

module masked_vertical_fade_blend #(
    parameter int unsigned MAX_ROWS = 4096
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [31:0] src_pixel, [63:32] dst_pixel, [71:64] mask_value, [83:72] row_index, [87:84] zero
    input  wire logic [mvfb_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // master stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [31:0] out_pixel
    output logic [mvfb_pkg::PIX_W-1:0]              m_axis_tdata,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [3:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    localparam int unsigned HCAP  = (MAX_ROWS < 8191) ? MAX_ROWS : 8191;
    localparam int unsigned DW    = $clog2(HCAP + 1);
    localparam int unsigned NUM_W = mvfb_pkg::NUM_W;
    localparam int unsigned TR_W  = mvfb_pkg::TR_W;

    // ---------------- configuration ----------------
    logic [mvfb_pkg::LEVEL_W-1:0]  r_top;
    logic [mvfb_pkg::LEVEL_W-1:0]  r_bottom;
    logic [mvfb_pkg::HEIGHT_W-1:0] r_height;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= 15'd256;
            r_bottom <= 15'd256;
            r_height <= 13'd1;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                mvfb_pkg::REG_TOP:    r_top    <= pwdata[14:0];
                mvfb_pkg::REG_BOTTOM: r_bottom <= pwdata[14:0];
                mvfb_pkg::REG_HEIGHT: r_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            mvfb_pkg::REG_TOP:    prdata = {{17{r_top[14]}}, r_top};
            mvfb_pkg::REG_BOTTOM: prdata = {{17{r_bottom[14]}}, r_bottom};
            mvfb_pkg::REG_HEIGHT: prdata = {19'd0, r_height};
            default:              prdata = 32'd0;
        endcase
    end

    // derived constants; the user keeps them static while pixels are in flight, not enforced
    logic [15:0]                 diff;
    logic [15:0]                 ndiff;
    logic [mvfb_pkg::DMAG_W-1:0] n_dmag;
    logic [DW-1:0]               n_div;
    logic [mvfb_pkg::DMAG_W-1:0] r_dmag;
    logic                        r_dneg;
    logic [DW-1:0]               r_div;

    always_comb begin
        diff   = {r_bottom[14], r_bottom} - {r_top[14], r_top};
        ndiff  = 16'd0 - diff;
        n_dmag = diff[15] ? ndiff[14:0] : diff[14:0];
        if (r_height == '0) begin
            n_div = DW'(1);
        end else if (32'(r_height) > HCAP) begin
            n_div = DW'(HCAP);
        end else begin
            n_div = DW'(r_height);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dmag <= n_dmag;
        r_dneg <= diff[15];
        r_div  <= n_div;
    end

    // ---------------- pipeline ----------------
    logic en;
    logic r_skd_valid;

    assign en            = !r_skd_valid;
    assign s_axis_tready = en;

    // stage A: input register
    logic                        r_a_valid;
    mvfb_pkg::t_side             r_a_side;
    logic [mvfb_pkg::ROW_W-1:0]  r_a_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side.src  <= s_axis_tdata[31:0];
            r_a_side.dst  <= s_axis_tdata[63:32];
            r_a_side.mask <= s_axis_tdata[71:64];
            r_a_row       <= s_axis_tdata[83:72];
        end
    end

    // stage B (index 0) and divider stages 1..NUM_W
    logic            r_dv_valid [0:NUM_W];
    logic [DW-1:0]   r_dv_rem   [0:NUM_W];
    logic [NUM_W-1:0] r_dv_num  [0:NUM_W];
    logic            r_dv_neg   [0:NUM_W];
    mvfb_pkg::t_side r_dv_side  [0:NUM_W];

    logic [DW-1:0]    n_dv_rem [1:NUM_W];
    logic [NUM_W-1:0] n_dv_num [1:NUM_W];
    logic [NUM_W-1:0] n_prod;

    assign n_prod = {12'd0, r_dmag} * {15'd0, r_a_row};

    // one restoring step per stage: remainder picks up the next numerator bit,
    // the freed low bit of the numerator collects the quotient bit
    always_comb begin
        logic [DW:0] t;
        logic        ge;
        for (int k = 1; k <= NUM_W; k++) begin
            t           = {r_dv_rem[k-1], r_dv_num[k-1][NUM_W-1]};
            ge          = (t >= {1'b0, r_div});
            n_dv_rem[k] = ge ? DW'(t - {1'b0, r_div}) : t[DW-1:0];
            n_dv_num[k] = {r_dv_num[k-1][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_W; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv_valid[0] <= r_a_valid;
            for (int k = 1; k <= NUM_W; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0]  <= '0;
            r_dv_num[0]  <= n_prod;
            r_dv_neg[0]  <= r_dneg;
            r_dv_side[0] <= r_a_side;
            for (int k = 1; k <= NUM_W; k++) begin
                r_dv_rem[k]  <= n_dv_rem[k];
                r_dv_num[k]  <= n_dv_num[k];
                r_dv_neg[k]  <= r_dv_neg[k-1];
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // stage C: opacity = top +/- quotient, clamped to 0..256
    logic                r_c_valid;
    logic [TR_W-1:0]     r_c_tr;
    mvfb_pkg::t_side     r_c_side;
    logic [NUM_W+1:0]    top_x;
    logic [NUM_W+1:0]    quo_x;
    logic [NUM_W+1:0]    level;
    logic [TR_W-1:0]     n_c_tr;

    always_comb begin
        top_x = {{(NUM_W + 2 - mvfb_pkg::LEVEL_W){r_top[14]}}, r_top};
        quo_x = {2'b00, r_dv_num[NUM_W]};
        level = r_dv_neg[NUM_W] ? (top_x - quo_x) : (top_x + quo_x);
        if (level[NUM_W+1]) begin
            n_c_tr = '0;
        end else if (level > (NUM_W + 2)'(256)) begin
            n_c_tr = mvfb_pkg::TR_FULL;
        end else begin
            n_c_tr = level[TR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_dv_valid[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_tr   <= n_c_tr;
            r_c_side <= r_dv_side[NUM_W];
        end
    end

    // stage D: weight and special-case flags
    logic            r_d_valid;
    logic [7:0]      r_d_w;
    logic            r_d_copy;
    logic            r_d_keep;
    mvfb_pkg::t_side r_d_side;
    logic [16:0]     wprod;

    assign wprod = {9'd0, r_c_side.mask} * {8'd0, r_c_tr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_w    <= wprod[15:8];
            r_d_copy <= (r_c_side.mask == mvfb_pkg::MASK_FULL) && (r_c_tr == mvfb_pkg::TR_FULL);
            r_d_keep <= (wprod[15:8] == 8'd0);
            r_d_side <= r_c_side;
        end
    end

    // stage E: channel mix and result select
    function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] w);
        logic [16:0] sw;
        logic [16:0] dw;
        logic [16:0] sum;
        sw  = {9'd0, s} * {9'd0, w};
        dw  = {9'd0, d} * (17'd256 - {9'd0, w});
        sum = sw + dw;
        return sum[15:8];
    endfunction

    logic                    r_res_valid;
    logic [mvfb_pkg::PIX_W-1:0] r_res_pixel;
    logic [mvfb_pkg::PIX_W-1:0] n_res_pixel;

    always_comb begin
        if (r_d_copy) begin
            n_res_pixel = r_d_side.src;
        end else if (r_d_keep) begin
            n_res_pixel = r_d_side.dst;
        end else begin
            n_res_pixel = {8'h00,
                           mix(r_d_side.src[23:16], r_d_side.dst[23:16], r_d_w),
                           mix(r_d_side.src[15:8],  r_d_side.dst[15:8],  r_d_w),
                           mix(r_d_side.src[7:0],   r_d_side.dst[7:0],   r_d_w)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (en) begin
            r_res_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_pixel <= n_res_pixel;
        end
    end

    // ---------------- output register and skid entry ----------------
    logic                       r_out_valid;
    logic [mvfb_pkg::PIX_W-1:0] r_out_pixel;
    logic [mvfb_pkg::PIX_W-1:0] r_skd_pixel;
    logic                       take;
    logic                       push;

    assign take = r_out_valid && m_axis_tready;
    assign push = en && r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            // output held: park the transaction leaving the pipeline
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            r_out_pixel <= r_skd_valid ? r_skd_pixel : r_res_pixel;
        end
        if (!(take || !r_out_valid) && push) begin
            r_skd_pixel <= r_res_pixel;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pixel;

endmodule

`default_nettype wire

// File: tb/masked_vertical_fade_blend_checker.sv
module masked_vertical_fade_blend_checker #(
    parameter int unsigned MAX_ROWS = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_valid,
    input  wire logic                              i_s_ready,
    // [31:0] src_pixel, [63:32] dst_pixel, [71:64] mask_value, [83:72] row_index, [87:84] zero
    input  wire logic [mvfb_pkg::S_DATA_W-1:0]     i_s_data,
    input  wire logic                              i_m_valid,
    input  wire logic                              i_m_ready,
    // [31:0] out_pixel
    input  wire logic [mvfb_pkg::PIX_W-1:0]        i_m_data,
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic [3:0]                        i_paddr,
    input  wire logic [31:0]                       i_pwdata,
    input  wire logic                              i_pready,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [mvfb_pkg::LEVEL_W-1:0] cfg_top;
    logic signed [mvfb_pkg::LEVEL_W-1:0] cfg_bottom;
    logic [mvfb_pkg::HEIGHT_W-1:0]       cfg_height;

    logic [mvfb_pkg::PIX_W-1:0] expected_pixels[$];
    int fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        fail_total++;
    endtask

    // row opacity from the gradient, weight from mask, then copy, keep or mix
    function automatic logic [mvfb_pkg::PIX_W-1:0] fade_blend_pixel(
        input logic [mvfb_pkg::PIX_W-1:0]  src,
        input logic [mvfb_pkg::PIX_W-1:0]  dst,
        input logic [mvfb_pkg::MASK_W-1:0] mask,
        input logic [mvfb_pkg::ROW_W-1:0]  row
    );
        longint rows;
        longint opacity;
        int unsigned weight;
        int unsigned s_ch;
        int unsigned d_ch;
        int c;
        logic [mvfb_pkg::PIX_W-1:0] mixed;

        rows = longint'(cfg_height);
        if (rows < 1) begin
            rows = 1;
        end
        if (rows > longint'(MAX_ROWS)) begin
            rows = longint'(MAX_ROWS);
        end
        // signed division truncates toward zero
        opacity = longint'(cfg_top) +
                  ((longint'(cfg_bottom) - longint'(cfg_top)) * longint'(row)) / rows;
        if (opacity < 0) begin
            opacity = 0;
        end
        if (opacity > longint'(mvfb_pkg::TR_FULL)) begin
            opacity = longint'(mvfb_pkg::TR_FULL);
        end
        weight = int'((longint'(mask) * opacity) >> 8);

        if (mask == mvfb_pkg::MASK_FULL && opacity == longint'(mvfb_pkg::TR_FULL)) begin
            return src;
        end
        if (weight == 0) begin
            return dst;
        end
        mixed = '0;
        for (c = 0; c < 3; c++) begin
            s_ch = src[8*c +: 8];
            d_ch = dst[8*c +: 8];
            mixed[8*c +: 8] = 8'((s_ch * weight + (256 - weight) * d_ch) >> 8);
        end
        return mixed;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_top    = 15'sd256;
            cfg_bottom = 15'sd256;
            cfg_height = 13'd1;
            expected_pixels.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    mvfb_pkg::REG_TOP: begin
                        cfg_top = i_pwdata[mvfb_pkg::LEVEL_W-1:0];
                    end
                    mvfb_pkg::REG_BOTTOM: begin
                        cfg_bottom = i_pwdata[mvfb_pkg::LEVEL_W-1:0];
                    end
                    mvfb_pkg::REG_HEIGHT: begin
                        cfg_height = i_pwdata[mvfb_pkg::HEIGHT_W-1:0];
                    end
                    default: begin
                        // no register here, write dropped
                    end
                endcase
            end

            if (i_m_valid && i_m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("out_pixel %h with no transaction pending",
                                              i_m_data));
                end else if (i_m_data !== expected_pixels[0]) begin
                    report_mismatch($sformatf("out_pixel got %h, expected %h",
                                              i_m_data, expected_pixels[0]));
                    void'(expected_pixels.pop_front());
                end else begin
                    void'(expected_pixels.pop_front());
                end
            end

            if (i_s_valid && i_s_ready) begin
                expected_pixels.push_back(fade_blend_pixel(i_s_data[31:0], i_s_data[63:32],
                                                           i_s_data[71:64], i_s_data[83:72]));
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: tb/masked_vertical_fade_blend_test.sv
module masked_vertical_fade_blend_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_ROWS    = 4096;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_ITEMS = 120;
    // address 12 decodes to no register
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // [31:0] src_pixel, [63:32] dst_pixel, [71:64] mask_value, [83:72] row_index, [87:84] zero
    logic [mvfb_pkg::S_DATA_W-1:0]     s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // [31:0] out_pixel
    logic [mvfb_pkg::PIX_W-1:0]        m_axis_tdata;
    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [3:0]                        paddr   = '0;
    logic [31:0]                       pwdata  = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    int fail_count;
    int pending_pixels;

    int          burst_left   = 0;
    bit          gaps_on      = 1'b1;
    logic [12:0] phase_height = 13'd1;

    t_rx_mode    rx_mode = RX_FREE;
    int          rx_span = 0;
    int unsigned rx_beat = 0;

    always #5 i_clk = ~i_clk;

    masked_vertical_fade_blend #(
        .MAX_ROWS(MAX_ROWS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    masked_vertical_fade_blend_checker #(
        .MAX_ROWS(MAX_ROWS)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .i_s_ready   (s_axis_tready),
        .i_s_data    (s_axis_tdata),
        .i_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .i_m_data    (m_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending_pixels)
    );

    // receiver back-pressure: modes held for random spans
    always @(posedge i_clk) begin
        rx_beat <= rx_beat + 1;
        if (rx_span == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_span <= $urandom_range(16, 160);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_FREE: begin
                m_axis_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            RX_PERIODIC: begin
                m_axis_tready <= (rx_beat[1:0] == 2'd0);
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (index == mvfb_pkg::REG_HEIGHT) begin
            phase_height = value[12:0];
        end
        @(posedge i_clk);
    endtask

    // gap (if any) goes before the transaction, so valid never drops and rises in one step
    task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst,
                              input logic [7:0] mask, input logic [11:0] row);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
            end
        end else begin
            burst_left--;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, row, mask, dst, src};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_level();
        int lvl;
        case ($urandom_range(0, 9))
            0: lvl = -16384;
            1: lvl = 16383;
            2: lvl = 0;
            3: lvl = 256;
            4, 5, 6: lvl = int'($urandom_range(0, 384)) - 64;
            7: lvl = int'($urandom_range(0, 16384)) - 8192;
            default: lvl = int'($urandom);
        endcase
        // upper bits are don't-care to the register
        return {17'($urandom), 15'(lvl)};
    endfunction

    function automatic logic [31:0] pick_height();
        logic [12:0] h;
        case ($urandom_range(0, 9))
            0: h = 13'd0;
            1: h = 13'd1;
            2: h = 13'd4096;
            3: h = 13'($urandom_range(4097, 8191));
            4: h = 13'($urandom_range(1, 16));
            default: h = 13'($urandom_range(1, 4096));
        endcase
        return {19'($urandom), h};
    endfunction

    task automatic send_random_pixel();
        int unsigned rows;
        logic [7:0]  mask;
        logic [11:0] row;
        rows = (phase_height == 0) ? 1 :
               (phase_height > MAX_ROWS) ? MAX_ROWS : phase_height;
        // mostly rows inside the picture, some extrapolated
        if ($urandom_range(0, 4) == 0) begin
            row = 12'($urandom);
        end else begin
            row = 12'($urandom_range(0, rows - 1));
        end
        case ($urandom_range(0, 7))
            0: mask = 8'h00;
            1: mask = mvfb_pkg::MASK_FULL;
            default: mask = 8'($urandom);
        endcase
        send_pixel($urandom, $urandom, mask, row);
    endtask

    initial begin
        int phase;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset levels: full opacity everywhere
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, 12'd0);
        send_pixel(32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'h00, 12'd4095);
        send_pixel(32'h00FF_FFFF, 32'hFF00_0000, 8'hFE, 12'd4095);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 8'h01, 12'd0);
        send_pixel(32'h1234_5678, 32'h8765_4321, 8'h80, 12'd2048);
        wait_idle();

        // extreme levels, zero height, dead address
        apb_write(mvfb_pkg::REG_TOP, 32'h0000_4000);
        apb_write(mvfb_pkg::REG_BOTTOM, 32'hFFFF_3FFF);
        apb_write(mvfb_pkg::REG_HEIGHT, 32'h0000_0000);
        apb_write(REG_UNUSED, 32'h0000_0005);
        send_pixel(32'hDEAD_BEEF, 32'h0BAD_F00D, 8'hFF, 12'd0);
        send_pixel(32'hDEAD_BEEF, 32'h0BAD_F00D, 8'hFF, 12'd1);
        send_pixel(32'hC0FF_EE11, 32'h2233_4455, 8'hC8, 12'd4095);
        wait_idle();

        // height beyond the row limit saturates
        apb_write(mvfb_pkg::REG_TOP, 32'h0000_0000);
        apb_write(mvfb_pkg::REG_BOTTOM, 32'h0000_0100);
        apb_write(mvfb_pkg::REG_HEIGHT, 32'h0000_1FFF);
        send_pixel(32'h00AA_BBCC, 32'h0011_2233, 8'hFF, 12'd0);
        send_pixel(32'h00AA_BBCC, 32'h0011_2233, 8'hFF, 12'd2048);
        send_pixel(32'hFF80_7F01, 32'h007F_80FE, 8'hFF, 12'd4095);
        wait_idle();

        // falling gradient, inexact negative division, rows past the end
        apb_write(mvfb_pkg::REG_TOP, 32'h0000_0100);
        apb_write(mvfb_pkg::REG_BOTTOM, 32'h0000_0000);
        apb_write(mvfb_pkg::REG_HEIGHT, 32'h0000_0003);
        send_pixel(32'h0102_0304, 32'hF0E0_D0C0, 8'hFF, 12'd0);
        send_pixel(32'h0102_0304, 32'hF0E0_D0C0, 8'hFF, 12'd1);
        send_pixel(32'h0102_0304, 32'hF0E0_D0C0, 8'hFF, 12'd2);
        send_pixel(32'h0102_0304, 32'hF0E0_D0C0, 8'hFF, 12'd3);
        send_pixel(32'h0102_0304, 32'hF0E0_D0C0, 8'hFF, 12'd4);
        wait_idle();

        // top just below zero, far row clamps to opaque
        apb_write(mvfb_pkg::REG_TOP, 32'h0000_7FFF);
        apb_write(mvfb_pkg::REG_BOTTOM, 32'h0000_012C);
        apb_write(mvfb_pkg::REG_HEIGHT, 32'h0000_0007);
        send_pixel(32'h7F7F_7F7F, 32'h8080_8080, 8'hFF, 12'd1);
        send_pixel(32'h7F7F_7F7F, 32'h8080_8080, 8'hFF, 12'd5);
        send_pixel(32'h7F7F_7F7F, 32'h8080_8080, 8'hFF, 12'd4095);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                apb_write(mvfb_pkg::REG_TOP, pick_level());
            end
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                apb_write(mvfb_pkg::REG_BOTTOM, pick_level());
            end
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                apb_write(mvfb_pkg::REG_HEIGHT, pick_height());
            end
            if ($urandom_range(0, 5) == 0) begin
                apb_write(REG_UNUSED, $urandom);
            end
            repeat (PHASE_ITEMS) send_random_pixel();
            wait_idle();
        end

        // pipeline is 33 deep; catch any stray output
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("masked_vertical_fade_blend regression: pass");
        end else begin
            $display("masked_vertical_fade_blend regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("masked_vertical_fade_blend regression: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mvfb_pkg.sv
hw/rtl/masked_vertical_fade_blend.sv
tb/masked_vertical_fade_blend_checker.sv
tb/masked_vertical_fade_blend_test.sv
